// File: sv/gha_pkg.sv
// ============================================================================
// Generational handle allocator package
// Field widths, command and status codes, and the request and result item
// types shared by the allocator and its test environment.
// ============================================================================
`default_nettype none

package gha_pkg;

   localparam int HANDLE_W  = 8;
   localparam int GEN_W     = 32;
   localparam int STATUS_W  = 3;
   localparam int COMMAND_W = 2;

   // Command codes.
   localparam logic [COMMAND_W-1:0] CMD_ALLOC = 2'd0;
   localparam logic [COMMAND_W-1:0] CMD_FREE  = 2'd1;
   localparam logic [COMMAND_W-1:0] CMD_CHECK = 2'd2;

   // Status codes.
   localparam logic [STATUS_W-1:0] STATUS_OK      = 3'd0;
   localparam logic [STATUS_W-1:0] STATUS_FULL    = 3'd1;
   localparam logic [STATUS_W-1:0] STATUS_BAD     = 3'd2;
   localparam logic [STATUS_W-1:0] STATUS_RETIRED = 3'd3;
   localparam logic [STATUS_W-1:0] STATUS_STALE   = 3'd4;

   typedef struct packed {
      logic [COMMAND_W-1:0] command;
      logic [HANDLE_W-1:0]  handle;
      logic [GEN_W-1:0]     generation;
   } req_type;

   typedef struct packed {
      logic [HANDLE_W-1:0] result_handle;
      logic [GEN_W-1:0]    result_generation;
      logic [STATUS_W-1:0] status;
   } rsp_type;

endpackage

`default_nettype wire

// File: sv/gha_ram.sv
// ============================================================================
// Generic single-port-write RAM
// One write port and one read port; the read data is registered and holds
// its value in cycles without a read.
// ============================================================================
`default_nettype none

module gha_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

// File: sv/generational_handle_allocator.sv
// ============================================================================
// Generational handle allocator
// Hands out slot handles with a generation count per slot, recycles freed
// handles through a last-in first-out stack and checks handle and
// generation pairs for currency.
// ============================================================================
//
//   Channel   Ports                           Direction   Carries
//   --------  ------------------------------  ----------  ---------------------
//   request   req_valid, req_ready, req_data  in          command, handle, gen
//   result    rsp_valid, rsp_ready, rsp_data  out         handle, gen, status
//
// Each item is handled in steps: the slot memory and the stack memory are
// read as it is accepted, then the block decides, writes the memories back
// where the command calls for it and loads the result register. The next
// item is not read until the previous one has written back; the block can
// take a new item in the cycle after the previous one completes.
// Reset clears the counters and the control state only; there is no clearing
// pass, because the data of a slot is used only once it has been opened and
// that of a stack entry only while it lies below the fill count.
// A result that is not taken holds the decision step of the next item.
//
`default_nettype none

module generational_handle_allocator
   import gha_pkg::*;
#(
   parameter int SLOT_COUNT = 256,
   parameter int GEN_BITS   = 32
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_ready,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_ready,
   output rsp_type rsp_data
);

   // Index into the slot table, and a counter that can hold SLOT_COUNT itself.
   localparam int IDX_W   = $clog2(SLOT_COUNT);
   localparam int CNT_W   = $clog2(SLOT_COUNT + 1);
   localparam int CMP_W   = (CNT_W > HANDLE_W) ? CNT_W : HANDLE_W;
   // A slot word is the allocated bit above the generation.
   localparam int SLOT_W  = GEN_BITS + 1;
   // A stack word carries the handle and the generation it will be handed
   // out with, so that an allocate needs no second read of the slot table.
   localparam int STACK_W = IDX_W + GEN_BITS;
   // Generations at or above this value retire the slot on free.
   localparam logic [GEN_BITS-1:0] GEN_RETIRE = {{(GEN_BITS-1){1'b1}}, 1'b0};

   typedef enum logic {
      S_IDLE,
      S_EXEC
   } state_type;

   state_type        state_ff, state_in;
   req_type          req_ff;
   rsp_type          rsp_ff, rsp_in;
   logic             rsp_valid_ff, rsp_valid_in;
   logic [CNT_W-1:0] free_count_ff, free_count_in;
   logic [CNT_W-1:0] slots_opened_ff, slots_opened_in;

   logic accept;
   logic done;

   // Memory ports.
   logic               slot_we;
   logic [IDX_W-1:0]   slot_waddr;
   logic [SLOT_W-1:0]  slot_wdata;
   logic [SLOT_W-1:0]  slot_rdata;
   logic               stack_we;
   logic [IDX_W-1:0]   stack_waddr;
   logic [STACK_W-1:0] stack_wdata;
   logic [STACK_W-1:0] stack_rdata;

   // Fields of the words read back for the item in hand.
   logic                slot_alloc;
   logic [GEN_BITS-1:0] slot_gen;
   logic [IDX_W-1:0]    stack_idx;
   logic [GEN_BITS-1:0] stack_gen;
   logic [IDX_W-1:0]    req_idx;
   logic                in_range;

   assign accept = req_valid && req_ready;
   assign done   = (state_ff == S_EXEC) && (!rsp_valid_ff || rsp_ready);

   assign slot_alloc = slot_rdata[GEN_BITS];
   assign slot_gen   = slot_rdata[GEN_BITS-1:0];
   assign stack_idx  = stack_rdata[STACK_W-1:GEN_BITS];
   assign stack_gen  = stack_rdata[GEN_BITS-1:0];
   assign req_idx    = IDX_W'(req_ff.handle);
   assign in_range   = CMP_W'(req_ff.handle) < CMP_W'(slots_opened_ff);

   // Slot table: allocated bit and generation per slot. It is read at the
   // requested handle when the item is accepted.
   gha_ram #(
      .WIDTH (SLOT_W),
      .DEPTH (SLOT_COUNT)
   ) u_slot_ram (
      .clock   (clock),
      .wr_en   (slot_we && done),
      .wr_addr (slot_waddr),
      .wr_data (slot_wdata),
      .rd_en   (accept),
      .rd_addr (IDX_W'(req_data.handle)),
      .rd_data (slot_rdata)
   );

   // Free stack, read at its top entry when the item is accepted. When the
   // stack is empty the address wraps and the data is not used.
   gha_ram #(
      .WIDTH (STACK_W),
      .DEPTH (SLOT_COUNT)
   ) u_stack_ram (
      .clock   (clock),
      .wr_en   (stack_we && done),
      .wr_addr (stack_waddr),
      .wr_data (stack_wdata),
      .rd_en   (accept),
      .rd_addr (IDX_W'(free_count_ff - CNT_W'(1))),
      .rd_data (stack_rdata)
   );

   // Decision for the item in hand. All writes and counter updates take
   // effect only in the cycle in which the result register can be loaded.
   always_comb begin
      slot_we         = 1'b0;
      slot_waddr      = req_idx;
      slot_wdata      = {1'b0, slot_gen};
      stack_we        = 1'b0;
      stack_waddr     = IDX_W'(free_count_ff);
      stack_wdata     = {req_idx, slot_gen};
      free_count_in   = free_count_ff;
      slots_opened_in = slots_opened_ff;
      rsp_in          = '{result_handle:     req_ff.handle,
                          result_generation: '0,
                          status:            STATUS_BAD};

      case (req_ff.command)
         CMD_ALLOC: begin
            if (free_count_ff != '0) begin
               // Reuse the most recently freed handle.
               free_count_in = free_count_ff - CNT_W'(1);
               slot_we       = 1'b1;
               slot_waddr    = stack_idx;
               slot_wdata    = {1'b1, stack_gen};
               rsp_in        = '{result_handle:     HANDLE_W'(stack_idx),
                                 result_generation: GEN_W'(stack_gen),
                                 status:            STATUS_OK};
            end else if (slots_opened_ff < CNT_W'(SLOT_COUNT)) begin
               // Open a fresh slot at generation one.
               slots_opened_in = slots_opened_ff + CNT_W'(1);
               slot_we         = 1'b1;
               slot_waddr      = IDX_W'(slots_opened_ff);
               slot_wdata      = {1'b1, GEN_BITS'(1)};
               rsp_in          = '{result_handle:     HANDLE_W'(slots_opened_ff),
                                   result_generation: GEN_W'(1),
                                   status:            STATUS_OK};
            end else begin
               rsp_in = '{result_handle: '0, result_generation: '0,
                          status: STATUS_FULL};
            end
         end
         CMD_FREE: begin
            if (!in_range) begin
               rsp_in.status = STATUS_BAD;
            end else if (!slot_alloc) begin
               // Double free: report and leave everything as it is.
               rsp_in.result_generation = GEN_W'(slot_gen);
               rsp_in.status            = STATUS_BAD;
            end else if (slot_gen < GEN_RETIRE && free_count_ff < CNT_W'(SLOT_COUNT)) begin
               slot_we       = 1'b1;
               slot_wdata    = {1'b0, GEN_BITS'(slot_gen + GEN_BITS'(1))};
               stack_we      = 1'b1;
               stack_wdata   = {req_idx, GEN_BITS'(slot_gen + GEN_BITS'(1))};
               free_count_in = free_count_ff + CNT_W'(1);
               rsp_in.result_generation = GEN_W'(GEN_BITS'(slot_gen + GEN_BITS'(1)));
               rsp_in.status            = STATUS_OK;
            end else begin
               // Generation exhausted or stack full: the slot is retired and never reused.
               slot_we    = 1'b1;
               slot_wdata = {1'b0, slot_gen};
               rsp_in.result_generation = GEN_W'(slot_gen);
               rsp_in.status            = STATUS_RETIRED;
            end
         end
         CMD_CHECK: begin
            if (in_range) begin
               rsp_in.result_generation = GEN_W'(slot_gen);
               if (req_ff.generation != GEN_W'(slot_gen)) begin
                  rsp_in.status = STATUS_STALE;
               end else if (!slot_alloc) begin
                  rsp_in.status = STATUS_BAD;
               end else begin
                  rsp_in.status = STATUS_OK;
               end
            end
         end
         default: begin
            rsp_in.status = STATUS_BAD;
         end
      endcase
   end

   // Sequencer: idle until an item arrives, then the read-back and decision
   // state S_EXEC, held while the previous result is still waiting.
   always_comb begin
      state_in     = state_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               state_in = S_EXEC;
            end
         end
         S_EXEC: begin
            if (done) begin
               state_in     = S_IDLE;
               rsp_valid_in = 1'b1;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff        <= S_IDLE;
         rsp_valid_ff    <= 1'b0;
         free_count_ff   <= '0;
         slots_opened_ff <= '0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         if (done) begin
            free_count_ff   <= free_count_in;
            slots_opened_ff <= slots_opened_in;
         end
      end
      if (accept) begin
         req_ff <= req_data;
      end
      if (done) begin
         rsp_ff <= rsp_in;
      end
   end

   assign req_ready = (state_ff == S_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

`ifndef SYNTHESIS
   // Every handle on the free stack belongs to a slot that has been opened.
   a_stack_within_opened: assert property (@(posedge clock) disable iff (reset)
      free_count_ff <= slots_opened_ff)
      else $error("free stack holds more handles than slots opened");

   // Fresh slots are only ever opened, never given back.
   a_opened_monotonic: assert property (@(posedge clock) disable iff (reset)
      !$past(reset) |-> slots_opened_ff >= $past(slots_opened_ff))
      else $error("count of opened slots went down");

   // An accepted item closes the request side until it completes.
   a_one_in_flight: assert property (@(posedge clock) disable iff (reset)
      accept |=> !req_ready)
      else $error("request taken while an item is in flight");

   // A push onto the stack raises the fill count by exactly one.
   a_push_counts: assert property (@(posedge clock) disable iff (reset)
      (stack_we && done) |=> free_count_ff == CNT_W'($past(free_count_ff) + CNT_W'(1)))
      else $error("free stack push did not advance the fill count");
`endif

endmodule

`default_nettype wire
